@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port-level checker of the joint angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is held.
`define TLAJ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that is checked across reset as well.
`define TLAJ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/tlaj_pkg.sv @@
// Shared types, constants and functions of the joint angle block.
package tlaj_pkg;

    // Datapath widths.
    localparam int CW           = 36;
    localparam int ZW           = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int NORM_STAGES  = 5;
    localparam int LINK_W       = 8;
    localparam int LEN_W        = LINK_W + 6;
    localparam int REACH_W      = 15;

    localparam logic [LINK_W-1:0] UPPER_RESET = 8'd50;
    localparam logic [LINK_W-1:0] LOWER_RESET = 8'd40;
    localparam logic [ZW-1:0]     HALF_TURN   = 32'h8000_0000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_UPPER_LENGTH = 1'b0,
        CFG_LOWER_LENGTH = 1'b1
    } cfg_index_t;

    // Which clamp was applied to the distance.
    typedef enum logic [1:0] {
        RS_IN_RANGE = 2'd0,
        RS_OUTER    = 2'd1,
        RS_INNER    = 2'd2
    } reach_status_t;

    // One CORDIC stage: vector, accumulated angle and the origin flag.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
        logic                 zero;
    } cordic_t;

    // Arctangent of 2^-idx in units of 2^-32 turn.
    function automatic logic [ZW-1:0] atan_turn(input int idx);
        logic [ZW-1:0] a;
        unique case (idx)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Magnitude of a CORDIC word.
    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        logic [CW-1:0] r;
        r = v[CW-1] ? (~v + CW'(1)) : v;
        return r;
    endfunction

endpackage

@@ rtl/core/tlaj_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband.
module tlaj_sqrt #(
    parameter int RAD_W  = 34,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);
    localparam int N  = RAD_W / 2;
    localparam int RW = N + 3;

    logic [RW-1:0]     rem_reg   [N];
    logic [N-1:0]      root_reg  [N];
    logic [RAD_W-1:0]  rad_reg   [N];
    logic [SIDE_W-1:0] side_reg  [N];
    logic              valid_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic [RW-1:0]     rem_in;
        logic [N-1:0]      root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [RW-1:0]     cur;
        logic [RW-1:0]     trial;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = in_rad;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign rad_in   = rad_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        // Bring down the next bit pair and try the trial subtrahend.
        assign cur   = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= ge ? (cur - trial) : cur;
                root_reg[j] <= {root_in[N-2:0], ge};
                rad_reg[j]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

@@ rtl/core/tlaj_atan.sv @@
// Pipelined CORDIC arctangent: half-turn fold, normalizing shifts, 30 rotations.
module tlaj_atan #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [tlaj_pkg::CW-1:0] in_x,
    input  logic signed [tlaj_pkg::CW-1:0] in_y,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [tlaj_pkg::ZW-1:0]     out_z,
    output logic [SIDE_W-1:0]           out_side
);
    import tlaj_pkg::*;

    localparam int NST = 1 + NORM_STAGES + CORDIC_STEPS;

    cordic_t           st_reg    [NST];
    logic [SIDE_W-1:0] side_reg  [NST];
    logic              valid_reg [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        cordic_t nxt;

        if (g == 0) begin : g_fold
            // Fold the left half plane onto the right one.
            always_comb begin
                nxt.zero = (in_x == '0) && (in_y == '0);
                if (in_x[CW-1]) begin
                    nxt.x = -in_x;
                    nxt.y = -in_y;
                    nxt.z = HALF_TURN;
                end else begin
                    nxt.x = in_x;
                    nxt.y = in_y;
                    nxt.z = '0;
                end
            end
        end else if (g <= NORM_STAGES) begin : g_norm
            localparam int SH = 16 >> (g - 1);
            localparam logic [CW-1:0] LIM = CW'(1) << (31 - SH);
            // Shift while the result stays below 2^31, so the larger magnitude
            // lands in [2^30, 2^31) as repeated doubling would leave it.
            always_comb begin
                nxt = st_reg[g-1];
                if ((mag(st_reg[g-1].x) < LIM) && (mag(st_reg[g-1].y) < LIM)) begin
                    nxt.x = st_reg[g-1].x <<< SH;
                    nxt.y = st_reg[g-1].y <<< SH;
                end
            end
        end else begin : g_rot
            localparam int I = g - 1 - NORM_STAGES;
            localparam logic [ZW-1:0] A = atan_turn(I);
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            // One rotation toward the x axis.
            always_comb begin
                xs  = st_reg[g-1].x;
                ys  = st_reg[g-1].y;
                dx  = xs >>> I;
                dy  = ys >>> I;
                nxt = st_reg[g-1];
                if (ys > 0) begin
                    nxt.x = xs + dy;
                    nxt.y = ys - dx;
                    nxt.z = st_reg[g-1].z + A;
                end else begin
                    nxt.x = xs - dy;
                    nxt.y = ys + dx;
                    nxt.z = st_reg[g-1].z - A;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= (g == 0) ? in_valid : valid_reg[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g]   <= nxt;
                side_reg[g] <= (g == 0) ? in_side : side_reg[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_z     = st_reg[NST-1].zero ? '0 : st_reg[NST-1].z;
    assign out_side  = side_reg[NST-1];

endmodule

@@ rtl/core/two_link_arm_joint_angles.sv @@
// Top level: two-link arm joint angles from a target point, fully pipelined.
//
//  Channel  | Direction | Handshake          | Beat contents
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready  | target_x, target_y
//  m_       | out       | m_valid / m_ready  | shoulder_angle, elbow_direction, reach,
//           |           |                    | reach_status
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat is accepted per cycle while the skid register is empty; a result passes
// through the distance root, the 30-bit triangle roots and
// the 36-stage CORDIC units. Reset clears the valid bits and loads the link
// lengths 50 and 40. When the result port stalls, a skid register takes the
// beat in flight and the whole pipeline holds until it drains.
module two_link_arm_joint_angles #(
    parameter int COORD_BITS = 11,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_target_x,
    input  logic signed [COORD_BITS-1:0]         s_target_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ANGLE_BITS-1:0]                m_shoulder_angle,
    output logic [ANGLE_BITS-1:0]                m_elbow_direction,
    output logic [tlaj_pkg::REACH_W-1:0]         m_reach,
    output tlaj_pkg::reach_status_t              m_reach_status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  tlaj_pkg::cfg_index_t                 cfg_index,
    input  logic [tlaj_pkg::LINK_W-1:0]          cfg_data
);
    import tlaj_pkg::*;

    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DRAD_W  = SQ_W + 12;
    localparam int DROOT_W = DRAD_W / 2;
    localparam int CMP_W   = (DROOT_W > REACH_W) ? DROOT_W : REACH_W;
    localparam int D_W     = REACH_W + LEN_W + 1;
    localparam int N_W     = 2 * REACH_W + 2;
    localparam int TRAD_W  = 2 * D_W;
    localparam int TROOT_W = TRAD_W / 2;
    localparam logic [ZW-1:0] RND = ZW'(1) << (ZW - 1 - ANGLE_BITS);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } pt_t;

    typedef struct packed {
        pt_t                  pt;
        logic [REACH_W-1:0]   reach;
        reach_status_t        status;
        logic signed [N_W-1:0] na;
        logic                 za;
        logic                 zb;
    } tri_side_t;

    typedef struct packed {
        logic [REACH_W-1:0] reach;
        reach_status_t      status;
    } rs_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] shoulder;
        logic [ANGLE_BITS-1:0] elbow;
        logic [REACH_W-1:0]    reach;
        reach_status_t         status;
    } res_t;

    logic adv;
    logic produce;

    // Configuration registers.
    logic [LINK_W-1:0] upper_reg;
    logic [LINK_W-1:0] lower_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= UPPER_RESET;
            lower_reg <= LOWER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_UPPER_LENGTH: upper_reg <= cfg_data;
                CFG_LOWER_LENGTH: lower_reg <= cfg_data;
            endcase
        end
    end

    // Link lengths in 1/64 pixel and the bounds of the reachable annulus.
    logic [LEN_W-1:0]   u_len;
    logic [LEN_W-1:0]   l_len;
    logic [REACH_W-1:0] outer;
    logic [LEN_W-1:0]   inner;

    assign u_len = {upper_reg, 6'b0};
    assign l_len = {lower_reg, 6'b0};
    assign outer = REACH_W'(u_len) + REACH_W'(l_len);
    assign inner = (u_len > l_len) ? (u_len - l_len) : (l_len - u_len);

    // Stage: squares of the coordinates.
    logic                   sq_valid_reg;
    pt_t                    sq_pt_reg;
    logic signed [SQ_W-1:0] sq_xx_reg;
    logic signed [SQ_W-1:0] sq_yy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (adv) begin
            sq_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_pt_reg.x <= s_target_x;
            sq_pt_reg.y <= s_target_y;
            sq_xx_reg   <= s_target_x * s_target_x;
            sq_yy_reg   <= s_target_y * s_target_y;
        end
    end

    // Stage: squared distance.
    logic            sm_valid_reg;
    pt_t             sm_pt_reg;
    logic [SQ_W-1:0] sm_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_valid_reg <= 1'b0;
        end else if (adv) begin
            sm_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sm_pt_reg  <= sq_pt_reg;
            sm_sum_reg <= unsigned'(sq_xx_reg) + unsigned'(sq_yy_reg);
        end
    end

    // Distance in 1/64 pixel.
    logic               dist_valid;
    logic [DROOT_W-1:0] dist_root;
    pt_t                dist_pt;

    tlaj_sqrt #(
        .RAD_W  (DRAD_W),
        .SIDE_W ($bits(pt_t))
    ) u_dist_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sm_valid_reg),
        .in_rad    ({sm_sum_reg, 12'b0}),
        .in_side   (sm_pt_reg),
        .out_valid (dist_valid),
        .out_root  (dist_root),
        .out_side  (dist_pt)
    );

    // Stage: clamp to the annulus.
    logic               cl_valid_reg;
    pt_t                cl_pt_reg;
    logic [REACH_W-1:0] cl_reach_reg;
    reach_status_t      cl_status_reg;
    logic [CMP_W-1:0]   dist_c;
    logic [REACH_W-1:0] reach_next;
    reach_status_t      status_next;

    always_comb begin
        dist_c = CMP_W'(dist_root);
        priority if (dist_c > CMP_W'(outer)) begin
            reach_next  = outer;
            status_next = RS_OUTER;
        end else if (dist_c < CMP_W'(inner)) begin
            reach_next  = REACH_W'(inner);
            status_next = RS_INNER;
        end else begin
            reach_next  = dist_c[REACH_W-1:0];
            status_next = RS_IN_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_valid_reg <= 1'b0;
        end else if (adv) begin
            cl_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cl_pt_reg     <= dist_pt;
            cl_reach_reg  <= reach_next;
            cl_status_reg <= status_next;
        end
    end

    // Stage: products for the law of cosines.
    logic                       pr_valid_reg;
    pt_t                        pr_pt_reg;
    logic [REACH_W-1:0]         pr_reach_reg;
    reach_status_t              pr_status_reg;
    logic [2*REACH_W-1:0]       pr_rr_reg;
    logic [2*LEN_W-1:0]         pr_uu_reg;
    logic [2*LEN_W-1:0]         pr_ll_reg;
    logic [REACH_W+LEN_W-1:0]   pr_ru_reg;
    logic [2*LEN_W-1:0]         pr_lu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
        end else if (adv) begin
            pr_valid_reg <= cl_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_pt_reg     <= cl_pt_reg;
            pr_reach_reg  <= cl_reach_reg;
            pr_status_reg <= cl_status_reg;
            pr_rr_reg     <= cl_reach_reg * cl_reach_reg;
            pr_uu_reg     <= u_len * u_len;
            pr_ll_reg     <= l_len * l_len;
            pr_ru_reg     <= cl_reach_reg * u_len;
            pr_lu_reg     <= l_len * u_len;
        end
    end

    // Stage: numerators and denominators of both cosines.
    logic                  lw_valid_reg;
    pt_t                   lw_pt_reg;
    logic [REACH_W-1:0]    lw_reach_reg;
    reach_status_t         lw_status_reg;
    logic signed [N_W-1:0] lw_na_reg;
    logic signed [N_W-1:0] lw_nb_reg;
    logic [D_W-1:0]        lw_da_reg;
    logic [D_W-1:0]        lw_db_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (adv) begin
            lw_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lw_pt_reg     <= pr_pt_reg;
            lw_reach_reg  <= pr_reach_reg;
            lw_status_reg <= pr_status_reg;
            lw_na_reg     <= $signed(N_W'(pr_rr_reg) + N_W'(pr_uu_reg) - N_W'(pr_ll_reg));
            lw_nb_reg     <= $signed(N_W'(pr_ll_reg) + N_W'(pr_uu_reg) - N_W'(pr_rr_reg));
            lw_da_reg     <= {pr_ru_reg, 1'b0};
            lw_db_reg     <= D_W'({pr_lu_reg, 1'b0});
        end
    end

    // Stage: squares of numerators and denominators.
    logic                      qs_valid_reg;
    pt_t                       qs_pt_reg;
    logic [REACH_W-1:0]        qs_reach_reg;
    reach_status_t             qs_status_reg;
    logic signed [N_W-1:0]     qs_na_reg;
    logic signed [N_W-1:0]     qs_nb_reg;
    logic [TRAD_W-1:0]         qs_d2a_reg;
    logic [TRAD_W-1:0]         qs_d2b_reg;
    logic signed [2*N_W-1:0]   qs_n2a_reg;
    logic signed [2*N_W-1:0]   qs_n2b_reg;
    logic                      qs_za_reg;
    logic                      qs_zb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qs_valid_reg <= 1'b0;
        end else if (adv) begin
            qs_valid_reg <= lw_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qs_pt_reg     <= lw_pt_reg;
            qs_reach_reg  <= lw_reach_reg;
            qs_status_reg <= lw_status_reg;
            qs_na_reg     <= lw_na_reg;
            qs_nb_reg     <= lw_nb_reg;
            qs_d2a_reg    <= lw_da_reg * lw_da_reg;
            qs_d2b_reg    <= lw_db_reg * lw_db_reg;
            qs_n2a_reg    <= lw_na_reg * lw_na_reg;
            qs_n2b_reg    <= lw_nb_reg * lw_nb_reg;
            qs_za_reg     <= (lw_da_reg == '0);
            qs_zb_reg     <= (lw_db_reg == '0);
        end
    end

    // Stage: radicands d^2 - n^2, zero beyond the triangle.
    logic              df_valid_reg;
    tri_side_t         df_side_reg;
    logic signed [N_W-1:0] df_nb_reg;
    logic [TRAD_W-1:0] df_rada_reg;
    logic [TRAD_W-1:0] df_radb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            df_valid_reg <= 1'b0;
        end else if (adv) begin
            df_valid_reg <= qs_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            df_side_reg.pt     <= qs_pt_reg;
            df_side_reg.reach  <= qs_reach_reg;
            df_side_reg.status <= qs_status_reg;
            df_side_reg.na     <= qs_na_reg;
            df_side_reg.za     <= qs_za_reg;
            df_side_reg.zb     <= qs_zb_reg;
            df_nb_reg          <= qs_nb_reg;
            df_rada_reg <= ((2*N_W)'(qs_d2a_reg) > unsigned'(qs_n2a_reg))
                         ? (qs_d2a_reg - qs_n2a_reg[TRAD_W-1:0]) : '0;
            df_radb_reg <= ((2*N_W)'(qs_d2b_reg) > unsigned'(qs_n2b_reg))
                         ? (qs_d2b_reg - qs_n2b_reg[TRAD_W-1:0]) : '0;
        end
    end

    // Triangle roots for both angles.
    logic                  tr_valid;
    logic [TROOT_W-1:0]    tr_sa;
    logic [TROOT_W-1:0]    tr_sb;
    tri_side_t             tr_side;
    logic signed [N_W-1:0] tr_nb;

    tlaj_sqrt #(
        .RAD_W  (TRAD_W),
        .SIDE_W ($bits(tri_side_t))
    ) u_alfa_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (df_valid_reg),
        .in_rad    (df_rada_reg),
        .in_side   (df_side_reg),
        .out_valid (tr_valid),
        .out_root  (tr_sa),
        .out_side  (tr_side)
    );

    tlaj_sqrt #(
        .RAD_W  (TRAD_W),
        .SIDE_W (N_W)
    ) u_beta_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (df_valid_reg),
        .in_rad    (df_radb_reg),
        .in_side   (df_nb_reg),
        .out_valid (),
        .out_root  (tr_sb),
        .out_side  (tr_nb)
    );

    // Three CORDIC units in lockstep: bearing, alfa and beta.
    logic                 at_valid;
    logic [ZW-1:0]        at_bearing;
    logic [ZW-1:0]        at_alfa;
    logic [ZW-1:0]        at_beta;
    rs_t                  at_rs;
    logic                 at_za;
    logic                 at_zb;
    rs_t                  tr_rs;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;

    assign tr_rs.reach  = tr_side.reach;
    assign tr_rs.status = tr_side.status;
    assign bx = {{(CW-COORD_BITS){tr_side.pt.x[COORD_BITS-1]}}, tr_side.pt.x};
    assign by = {{(CW-COORD_BITS){tr_side.pt.y[COORD_BITS-1]}}, tr_side.pt.y};
    assign ax = {{(CW-N_W){tr_side.na[N_W-1]}}, tr_side.na};
    assign ay = CW'(tr_sa);
    assign cx = {{(CW-N_W){tr_nb[N_W-1]}}, tr_nb};
    assign cy = CW'(tr_sb);

    tlaj_atan #(
        .SIDE_W ($bits(rs_t))
    ) u_bearing_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (tr_valid),
        .in_x      (bx),
        .in_y      (by),
        .in_side   (tr_rs),
        .out_valid (at_valid),
        .out_z     (at_bearing),
        .out_side  (at_rs)
    );

    tlaj_atan #(
        .SIDE_W (1)
    ) u_alfa_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (tr_valid),
        .in_x      (ax),
        .in_y      (ay),
        .in_side   (tr_side.za),
        .out_valid (),
        .out_z     (at_alfa),
        .out_side  (at_za)
    );

    tlaj_atan #(
        .SIDE_W (1)
    ) u_beta_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (tr_valid),
        .in_x      (cx),
        .in_y      (cy),
        .in_side   (tr_side.zb),
        .out_valid (),
        .out_z     (at_beta),
        .out_side  (at_zb)
    );

    // Stage: shoulder angle and the half-turn-plus-beta offset.
    logic          cb_valid_reg;
    rs_t           cb_rs_reg;
    logic [ZW-1:0] cb_shoulder_reg;
    logic [ZW-1:0] cb_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_valid_reg <= 1'b0;
        end else if (adv) begin
            cb_valid_reg <= at_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cb_rs_reg       <= at_rs;
            cb_shoulder_reg <= at_bearing + (at_za ? '0 : at_alfa);
            cb_offset_reg   <= HALF_TURN + (at_zb ? '0 : at_beta);
        end
    end

    // Stage: elbow direction.
    logic          en_valid_reg;
    rs_t           en_rs_reg;
    logic [ZW-1:0] en_shoulder_reg;
    logic [ZW-1:0] en_elbow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_valid_reg <= 1'b0;
        end else if (adv) begin
            en_valid_reg <= cb_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            en_rs_reg       <= cb_rs_reg;
            en_shoulder_reg <= cb_shoulder_reg;
            en_elbow_reg    <= cb_shoulder_reg + cb_offset_reg;
        end
    end

    // Round both angles to the output resolution.
    logic [ZW-1:0] shoulder_rnd;
    logic [ZW-1:0] elbow_rnd;
    res_t          res_next;

    assign shoulder_rnd     = en_shoulder_reg + RND;
    assign elbow_rnd        = en_elbow_reg + RND;
    assign res_next.shoulder = shoulder_rnd[ZW-1 -: ANGLE_BITS];
    assign res_next.elbow    = elbow_rnd[ZW-1 -: ANGLE_BITS];
    assign res_next.reach    = en_rs_reg.reach;
    assign res_next.status   = en_rs_reg.status;

    // Output register with a one-beat skid; the pipeline holds while the skid is full.
    logic m_valid_reg;
    logic skid_valid_reg;
    res_t res_reg;
    res_t skid_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign produce = adv && en_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (produce) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                res_reg <= skid_reg;
            end
        end else if (produce) begin
            if (!m_valid_reg || m_ready) begin
                res_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_shoulder_angle  = res_reg.shoulder;
    assign m_elbow_direction = res_reg.elbow;
    assign m_reach           = res_reg.reach;
    assign m_reach_status    = res_reg.status;

endmodule

@@ rtl/core/tlaj_checker.sv @@
// Port-level checker for the joint angle block and its bind statement.
`include "assert_macros.svh"

module tlaj_checker #(
    parameter int COORD_BITS = 11,
    parameter int ANGLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ANGLE_BITS-1:0]         m_shoulder_angle,
    input logic [ANGLE_BITS-1:0]         m_elbow_direction,
    input logic [tlaj_pkg::REACH_W-1:0]  m_reach,
    input tlaj_pkg::reach_status_t       m_reach_status
);
    import tlaj_pkg::*;

    localparam logic [REACH_W-1:0] MAX_REACH = 15'd32640;
    localparam int UNUSED_COORD = COORD_BITS;

    // A stalled result beat keeps its contents.
    `TLAJ_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_shoulder_angle) && $stable(m_elbow_direction) && $stable(m_reach) && $stable(m_reach_status), "result beat changed under stall")

    // Input is refused only while a result beat is waiting at the output.
    `TLAJ_ASSERT(a_ready, aclk, aresetn, !s_ready |-> m_valid && (UNUSED_COORD > 0), "input stalled with empty output")

    // The clamped reach never exceeds the largest outer bound.
    `TLAJ_ASSERT(a_reach, aclk, aresetn, m_valid |-> m_reach <= MAX_REACH, "reach beyond largest annulus")

    // Reset empties the pipeline and opens the input.
    `TLAJ_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid && s_ready, "state after reset")

endmodule

bind two_link_arm_joint_angles tlaj_checker #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_tlaj_checker (.*);

@@ dv/tlaj_angle_checker.sv @@
// Checker for the joint angle block: predicts each result and compares it field by field.
`timescale 1ns / 100ps

module tlaj_angle_checker #(
    parameter int COORD_BITS = 11,
    parameter int ANGLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_target_x,
    input  logic signed [COORD_BITS-1:0]      s_target_y,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [ANGLE_BITS-1:0]             m_shoulder_angle,
    input  logic [ANGLE_BITS-1:0]             m_elbow_direction,
    input  logic [tlaj_pkg::REACH_W-1:0]      m_reach,
    input  tlaj_pkg::reach_status_t           m_reach_status,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  tlaj_pkg::cfg_index_t              cfg_index,
    input  logic [tlaj_pkg::LINK_W-1:0]       cfg_data,
    output int                                fail_count,
    output int                                angles_pending
);
    import tlaj_pkg::*;

    typedef struct {
        logic [ANGLE_BITS-1:0] shoulder;
        logic [ANGLE_BITS-1:0] elbow;
        logic [REACH_W-1:0]    reach;
        reach_status_t         status;
    } joint_angles_t;

    joint_angles_t        expected_angles[$];
    logic [LINK_W-1:0]    upper_len;
    logic [LINK_W-1:0]    lower_len;

    // Arctangent table in 2^-32 turn.
    localparam longint unsigned ATAN_STEP[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    // Bitwise integer square root, rounded down.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC giving the bearing of (x, y) in 2^-32 turn.
    function automatic logic [31:0] bearing_turns(longint y, longint x);
        logic [31:0] z;
        longint      dx;
        longint      dy;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        while ((x < 0 ? -x : x) < (64'sd1 <<< 30) && (y < 0 ? -y : y) < (64'sd1 <<< 30)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 30; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy;
                y = y - dx;
                z = z + 32'(ATAN_STEP[i]);
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - 32'(ATAN_STEP[i]);
            end
        end
        return z;
    endfunction

    // Arc cosine of n/d through atan2 of the triangle root.
    function automatic logic [31:0] cosine_angle(longint n, longint d);
        longint unsigned n2;
        longint unsigned d2;
        longint unsigned s;
        if (d <= 0) return '0;
        n2 = longint'(n < 0 ? -n : n) * longint'(n < 0 ? -n : n);
        d2 = d * d;
        s = (d2 > n2) ? root_floor(d2 - n2) : 0;
        return bearing_turns(longint'(s), n);
    endfunction

    // Round a 2^-32 turn angle to the output width.
    function automatic logic [ANGLE_BITS-1:0] round_angle(logic [31:0] z);
        logic [31:0] r;
        r = z + (32'd1 << (31 - ANGLE_BITS));
        return ANGLE_BITS'(r >> (32 - ANGLE_BITS));
    endfunction

    function automatic joint_angles_t solve_joint_angles(longint x, longint y,
                                                         longint ulen, longint llen);
        joint_angles_t   res;
        longint          u;
        longint          l;
        longint          r;
        longint unsigned raw_dist;
        longint unsigned outer;
        longint unsigned inner;
        logic [31:0]     alfa;
        logic [31:0]     beta;
        logic [31:0]     shoulder;
        u = ulen * 64;
        l = llen * 64;
        raw_dist = root_floor(longint'(x * x + y * y) << 12);
        outer = u + l;
        inner = (u > l) ? u - l : l - u;
        res.status = RS_IN_RANGE;
        r = longint'(raw_dist);
        if (raw_dist > outer) begin
            r = longint'(outer);
            res.status = RS_OUTER;
        end else if (raw_dist < inner) begin
            r = longint'(inner);
            res.status = RS_INNER;
        end
        alfa = cosine_angle(r * r + u * u - l * l, 2 * r * u);
        beta = cosine_angle(l * l + u * u - r * r, 2 * l * u);
        shoulder = bearing_turns(y, x) + alfa;
        res.shoulder = round_angle(shoulder);
        res.elbow = round_angle(shoulder + HALF_TURN + beta);
        res.reach = REACH_W'(r);
        return res;
    endfunction

    assign angles_pending = expected_angles.size();

    // Track link lengths, predict accepted targets and check result beats.
    always @(posedge aclk) begin
        joint_angles_t exp_beat;
        if (!aresetn) begin
            upper_len <= UPPER_RESET;
            lower_len <= LOWER_RESET;
            expected_angles.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_UPPER_LENGTH) upper_len <= cfg_data;
                else lower_len <= cfg_data;
            end
            if (s_valid && s_ready) begin
                expected_angles.push_back(solve_joint_angles(s_target_x, s_target_y,
                                                             upper_len, lower_len));
            end
            if (m_valid && m_ready) begin
                if (expected_angles.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with no target outstanding", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_beat = expected_angles.pop_front();
                    if (m_shoulder_angle !== exp_beat.shoulder ||
                        m_elbow_direction !== exp_beat.elbow ||
                        m_reach !== exp_beat.reach ||
                        m_reach_status !== exp_beat.status) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch shoulder %0d/%0d elbow %0d/%0d ",
                                      "reach %0d/%0d status %0d/%0d (expected/actual)"},
                                     $realtime, exp_beat.shoulder, m_shoulder_angle,
                                     exp_beat.elbow, m_elbow_direction, exp_beat.reach,
                                     m_reach, exp_beat.status, m_reach_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: clock, reset, target and link length stimulus, and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import tlaj_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int ANGLE_BITS = 16;
    localparam int LATENCY    = COORD_BITS + 81;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [COORD_BITS-1:0]  s_target_x;
    logic signed [COORD_BITS-1:0]  s_target_y;
    logic                          m_valid;
    logic                          m_ready;
    logic [ANGLE_BITS-1:0]         m_shoulder_angle;
    logic [ANGLE_BITS-1:0]         m_elbow_direction;
    logic [REACH_W-1:0]            m_reach;
    reach_status_t                 m_reach_status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    cfg_index_t                    cfg_index;
    logic [LINK_W-1:0]             cfg_data;
    int                            fail_count;
    int                            angles_pending;
    bit                            steady_flow;
    int                            upper_now;
    int                            lower_now;

    two_link_arm_joint_angles #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) i_dut (.*);

    tlaj_angle_checker #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle length: mostly short, now and then long, none while flow is steady.
    function automatic int idle_cycles();
        int pick;
        if (steady_flow) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            stall = idle_cycles();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Send one target beat; valid stays high across back-to-back beats.
    task automatic send_target(int x, int y);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_target_x <= COORD_BITS'(x);
        s_target_y <= COORD_BITS'(y);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Write the link lengths once all results are back and the pipe is empty.
    task automatic set_links(int upper, int lower);
        s_valid <= 1'b0;
        wait (angles_pending == 0);
        repeat (LATENCY + 8) @(negedge aclk);
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_UPPER_LENGTH : CFG_LOWER_LENGTH;
            cfg_data  <= LINK_W'((i == 0) ? upper : lower);
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        upper_now = upper;
        lower_now = lower;
    endtask

    // Random target: mostly near the reachable ring, sometimes anywhere.
    task automatic random_targets(int count);
        int span;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            span = upper_now + lower_now + 4;
            if (span > 1023 || $urandom_range(0, 9) < 3) span = 1023;
            if ($urandom_range(0, 19) == 0)
                send_target($urandom_range(0, 1) ? -1024 : 1023,
                            $urandom_range(0, 2047) - 1024);
            else
                send_target($urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span);
        end
    endtask

    initial begin
        int settings[8][2] = '{'{50, 40}, '{255, 255}, '{1, 1}, '{0, 0},
                               '{0, 77}, '{200, 3}, '{37, 37}, '{3, 200}};
        s_valid = 1'b0;
        s_target_x = '0;
        s_target_y = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_UPPER_LENGTH;
        cfg_data = '0;
        steady_flow = 1'b0;
        upper_now = 50;
        lower_now = 40;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: pivot, field extremes, exact outer and inner bounds.
        send_target(0, 0);
        send_target(-1024, -1024);
        send_target(1023, 1023);
        send_target(-1024, 0);
        send_target(0, -1024);
        send_target(1023, -1024);
        send_target(-1, 0);
        send_target(0, 1);
        send_target(90, 0);
        send_target(0, -10);
        send_target(-5, 3);
        send_target(54, 72);
        // Equal links put the inner bound at zero, so the pivot gives zero reach.
        set_links(37, 37);
        send_target(0, 0);
        send_target(74, 0);
        send_target(-1, -1);
        // Zero link lengths give zero denominators.
        set_links(0, 0);
        send_target(0, 0);
        send_target(7, -9);
        set_links(0, 255);
        send_target(255, 0);
        send_target(100, 100);

        // Random phases over several link settings, extremes included.
        for (int p = 0; p < 12; p++) begin
            if (p < 8) set_links(settings[p][0], settings[p][1]);
            else set_links($urandom_range(0, 255), $urandom_range(0, 255));
            random_targets(155);
        end
        s_valid <= 1'b0;

        wait (angles_pending == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        if (fail_count == 0 && angles_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
